### rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared codes, frame constants and controller/datapath handshake types for
// the stepper command framer.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Request kinds
  localparam logic [1:0] REQ_REL    = 2'd0;
  localparam logic [1:0] REQ_ORIGIN = 2'd1;
  localparam logic [1:0] REQ_ABS    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Frame bytes
  localparam logic [7:0] WAKE_BYTE  = 8'hAA;
  localparam logic [7:0] SYNC0      = 8'hAA;
  localparam logic [7:0] SYNC1      = 8'h55;
  localparam logic [7:0] DEV_ADDR   = 8'h01;
  localparam logic [7:0] CMD_REL    = 8'h11;
  localparam logic [7:0] CMD_ORIGIN = 8'h12;
  localparam logic [7:0] CMD_ABS    = 8'h13;
  localparam logic [7:0] LEN_REL    = 8'h05;
  localparam logic [7:0] LEN_ORIGIN = 8'h00;
  localparam logic [7:0] LEN_ABS    = 8'h03;

  // Frame body lengths (checksum byte sits right after the body)
  localparam logic [3:0] BODY_REL    = 4'd10;
  localparam logic [3:0] BODY_ORIGIN = 4'd5;
  localparam logic [3:0] BODY_ABS    = 4'd8;
  localparam logic [3:0] PRE_LEN     = 4'd3;

  // Relative move saturation
  localparam logic signed [31:0] PULSE_SAT = 32'sd65535;

  // Angle reduction: floor(x/360) = (x * MOD_RECIP) >> MOD_SHIFT for x < 2^15
  localparam logic [15:0] MOD_RECIP = 16'd46604;
  localparam int          MOD_SHIFT = 24;
  localparam logic [8:0]  FULL_TURN = 9'd360;
  localparam logic signed [9:0] HALF_TURN = 10'sd180;

  // Angle pipeline: value of the wait counter at which commit is issued
  localparam logic [2:0] MATH_LAST = 3'd4;

  typedef struct packed {
    logic load;     // capture a new command
    logic commit;   // latch absolute move results and angle state
    logic advance;  // a byte beat was taken downstream
  } scf_cmd_t;

  typedef struct packed {
    logic last_beat;  // current byte is the checksum that ends the run
  } scf_stat_t;

endpackage

### rtl/scf_datapath.sv
// ----------------------------------------------------------------------------
// scf_datapath
// Command capture, angle reduction pipeline, link state, byte sequencing and
// running checksum for the stepper command framer.
// ----------------------------------------------------------------------------
module scf_datapath import scf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scf_cmd_t    cmd_i,
  output scf_stat_t   stat_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] pulse_amount_i,
  input  logic [15:0] target_angle_i,
  input  logic [14:0] angle_clamp_i,
  input  logic [15:0] pulses_per_degree_i,
  output logic [7:0]  tx_byte_o,
  output logic        is_preamble_o,
  output logic        pause_after_o,
  output logic        frame_last_o
);

  // Control and state
  logic [1:0]  req_q;
  logic        wake_q;
  logic        link_awake_q;
  logic [8:0]  cur_mod_q;
  logic [3:0]  idx_q;
  logic [7:0]  sum_q;

  // Payload
  logic [15:0] rel_mag_q, rel_mag_d;
  logic        rel_dir_q, rel_dir_d;
  logic [15:0] ang_q;
  logic [14:0] mag_q, mag_d;
  logic        neg_q;
  logic [30:0] prod_q;
  logic [15:0] qm_q;
  logic [8:0]  tgt_q, tgt_d;
  logic [15:0] pulses_q;
  logic        abs_dir_q, abs_dir_d;

  // Relative move saturation
  logic signed [31:0] pin;
  logic [31:0]        pneg;
  always_comb begin
    pin  = signed'(pulse_amount_i);
    pneg = 32'(-pin);
    rel_dir_d = !pin[31] && (pin != 32'sd0);
    if (pin > PULSE_SAT || pin < -PULSE_SAT) begin
      rel_mag_d = 16'hFFFF;
    end else if (pin[31]) begin
      rel_mag_d = pneg[15:0];
    end else begin
      rel_mag_d = pin[15:0];
    end
  end

  // Clamp magnitude of the target angle
  logic [15:0] a_abs;
  always_comb begin
    a_abs = ang_q[15] ? 16'(-ang_q) : ang_q;
    if (a_abs > {1'b0, angle_clamp_i}) begin
      mag_d = angle_clamp_i;
    end else begin
      mag_d = a_abs[14:0];
    end
  end

  // Remainder and sign fold
  logic [14:0] rem_full;
  logic [8:0]  rem;
  always_comb begin
    rem_full = mag_q - qm_q[14:0];
    rem      = rem_full[8:0];
    if (neg_q && rem != 9'd0) begin
      tgt_d = FULL_TURN - rem;
    end else begin
      tgt_d = rem;
    end
  end

  // Direction by the half-turn rule
  logic signed [9:0] diff;
  logic [24:0]       pscaled;
  always_comb begin
    diff    = signed'({1'b0, tgt_q}) - signed'({1'b0, cur_mod_q});
    pscaled = pulses_per_degree_i * tgt_q;
    if (diff > HALF_TURN) begin
      abs_dir_d = 1'b0;
    end else if (diff < -HALF_TURN) begin
      abs_dir_d = 1'b1;
    end else begin
      abs_dir_d = !diff[9];
    end
  end

  // Angle pipeline runs freely; inputs hold while the controller waits
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= ang_q[15];
    prod_q <= mag_q * MOD_RECIP;
    qm_q   <= prod_q[30:MOD_SHIFT] * FULL_TURN;
    tgt_q  <= tgt_d;
    if (cmd_i.load) begin
      ang_q     <= target_angle_i;
      rel_mag_q <= rel_mag_d;
      rel_dir_q <= rel_dir_d;
    end
    if (cmd_i.commit) begin
      pulses_q  <= pscaled[23:8];
      abs_dir_q <= abs_dir_d;
    end
  end

  // Byte selection
  logic [3:0] fi;
  logic [3:0] body_n;
  logic       pre;
  logic [7:0] body_byte;
  always_comb begin
    pre = wake_q && (idx_q < PRE_LEN);
    fi  = wake_q ? idx_q - PRE_LEN : idx_q;
    case (req_q)
      REQ_REL:    body_n = BODY_REL;
      REQ_ORIGIN: body_n = BODY_ORIGIN;
      default:    body_n = BODY_ABS;
    endcase
    body_byte = sum_q;
    case (fi)
      4'd0: body_byte = SYNC0;
      4'd1: body_byte = SYNC1;
      4'd2: body_byte = DEV_ADDR;
      4'd3: begin
        case (req_q)
          REQ_REL:    body_byte = CMD_REL;
          REQ_ORIGIN: body_byte = CMD_ORIGIN;
          default:    body_byte = CMD_ABS;
        endcase
      end
      4'd4: begin
        case (req_q)
          REQ_REL:    body_byte = LEN_REL;
          REQ_ORIGIN: body_byte = LEN_ORIGIN;
          default:    body_byte = LEN_ABS;
        endcase
      end
      4'd5: begin
        case (req_q)
          REQ_REL:    body_byte = {7'd0, rel_dir_q};
          REQ_ORIGIN: body_byte = sum_q;
          default:    body_byte = {7'd0, abs_dir_q};
        endcase
      end
      4'd6: body_byte = (req_q == REQ_REL) ? 8'd0 : pulses_q[7:0];
      4'd7: body_byte = (req_q == REQ_REL) ? 8'd0 : pulses_q[15:8];
      4'd8: body_byte = (req_q == REQ_REL) ? rel_mag_q[7:0] : sum_q;
      4'd9: body_byte = rel_mag_q[15:8];
      default: body_byte = sum_q;
    endcase
  end

  assign tx_byte_o        = pre ? WAKE_BYTE : body_byte;
  assign is_preamble_o    = pre;
  assign pause_after_o    = wake_q && (idx_q == PRE_LEN - 4'd1);
  assign frame_last_o     = !pre && (fi == body_n);
  assign stat_o.last_beat = frame_last_o;

  // Control state, link state and checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q        <= REQ_REL;
      wake_q       <= 1'b0;
      link_awake_q <= 1'b0;
      cur_mod_q    <= 9'd0;
      idx_q        <= 4'd0;
      sum_q        <= 8'd0;
    end else begin
      if (cmd_i.load) begin
        req_q  <= req_type_i;
        wake_q <= (req_type_i != REQ_REL) || !link_awake_q;
        idx_q  <= 4'd0;
        sum_q  <= 8'd0;
        case (req_type_i)
          REQ_REL:    link_awake_q <= 1'b1;
          REQ_ORIGIN: begin
            link_awake_q <= 1'b0;
            cur_mod_q    <= 9'd0;
          end
          default:    link_awake_q <= link_awake_q;
        endcase
      end
      if (cmd_i.commit) begin
        cur_mod_q <= tgt_q;
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + 4'd1;
        if (!pre && fi >= 4'd2 && fi != body_n) begin
          sum_q <= sum_q + body_byte;
        end
      end
    end
  end

endmodule

### rtl/scf_ctrl.sv
// ----------------------------------------------------------------------------
// scf_ctrl
// Sequencer for the stepper command framer: accept, wait out the angle
// pipeline for absolute rotate, then hand out bytes until the checksum beat.
// ----------------------------------------------------------------------------
module scf_ctrl import scf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output scf_cmd_t   cmd_o,
  input  scf_stat_t  stat_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MATH = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = 3'd0;
          case (req_type_i)
            REQ_ABS:    state_d = ST_MATH;
            REQ_UNUSED: state_d = ST_IDLE;
            default:    state_d = ST_SEND;
          endcase
        end
      end
      ST_MATH: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == MATH_LAST) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (stat_i.last_beat) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/stepper_command_framer_unit.sv
// ----------------------------------------------------------------------------
// stepper_command_framer_unit
// Turns stepper driver commands into serial frame bytes, one byte per beat.
// ----------------------------------------------------------------------------
// Latency: first byte is valid the cycle after accept for relative move and
//   set origin; absolute rotate first waits out the angle pipeline and commit.
// Flow: one command at a time; the next command is taken only after the
//   checksum byte of the frame has been sent, one byte per beat.
// Reset: asynchronous, active low; clears link state, current angle and
//   restores angle_clamp = 360 and pulses_per_degree = 256.
// ----------------------------------------------------------------------------
module stepper_command_framer_unit import scf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] pulse_amount, [47:32] target_angle
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // Byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
  output logic [1:0]  m_axis_tuser,   // [0] is_preamble, [1] pause_after
  output logic        m_axis_tlast,   // frame_last
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register map: word index taken from paddr[2]
  localparam logic REG_ANGLE_CLAMP = 1'b0;
  localparam logic REG_PPD         = 1'b1;

  logic [14:0] angle_clamp_q;
  logic [15:0] ppd_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_clamp_q <= 15'd360;
      ppd_q         <= 16'd256;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ANGLE_CLAMP: angle_clamp_q <= pwdata[14:0];
        REG_PPD:         ppd_q         <= pwdata[15:0];
        default:         ppd_q         <= ppd_q;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      REG_ANGLE_CLAMP: prdata = {17'd0, angle_clamp_q};
      default:         prdata = {16'd0, ppd_q};
    endcase
  end

  scf_cmd_t  cmd;
  scf_stat_t stat;

  // Sequencer: holds the input off while a command is in flight
  scf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath: capture, angle reduction, byte select and checksum
  scf_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .req_type_i          (s_axis_tuser),
    .pulse_amount_i      (s_axis_tdata[31:0]),
    .target_angle_i      (s_axis_tdata[47:32]),
    .angle_clamp_i       (angle_clamp_q),
    .pulses_per_degree_i (ppd_q),
    .tx_byte_o           (m_axis_tdata),
    .is_preamble_o       (m_axis_tuser[0]),
    .pause_after_o       (m_axis_tuser[1]),
    .frame_last_o        (m_axis_tlast)
  );

endmodule
